// ----- design/utf8_to_latin1_decoder_macros.svh -----
// Assertion helpers for the decoder top module.
// Each macro expects signals named clock and reset in the including scope.
`ifndef UTF8_TO_LATIN1_DECODER_MACROS_SVH
`define UTF8_TO_LATIN1_DECODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define U8L1_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8l1dec: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset
`define U8L1_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8l1dec: next-cycle check failed");

`endif

// ----- design/u8l1dec_pkg.sv -----
`default_nettype none

package u8l1dec_pkg;

   // Most characters per string that the block ever gives
   localparam int MAX_OUT = 1024;

   // Limit in force is min(out_limit, LIM_CAP); also the reset value of out_limit
   localparam logic [10:0] LIM_CAP = 11'((MAX_OUT > 2047) ? 2047 : MAX_OUT);

   // Byte values of interest
   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] LEAD_LOW    = 8'hC0;
   localparam logic [7:0] LEAD_HIGH   = 8'hC3;
   localparam logic [7:0] BIT6_MASK   = 8'h40;
   localparam logic [7:0] SUBST_CHAR  = 8'h5F;   // '_'
   localparam logic [7:0] CLASS_3B    = 8'hE0;
   localparam logic [7:0] CLASS_4B    = 8'hF0;
   localparam logic [7:0] CLASS_5B    = 8'hF8;
   localparam logic [7:0] CLASS_6B    = 8'hFC;
   localparam logic [7:0] CLASS_RUN   = 8'hFE;

   // Held lead byte awaiting its partner
   typedef enum logic [2:0] {
      LEAD_NONE = 3'd0,
      LEAD_C0   = 3'd1,
      LEAD_C1   = 3'd2,
      LEAD_C2   = 3'd3,
      LEAD_C3   = 3'd4
   } lead_type;

   // Per-string decoder state
   typedef struct packed {
      lead_type    pending_lead;
      logic [2:0]  skip_left;
      logic        skip_high_run;
      logic        legal_flag;
      logic [10:0] produced_count;
      logic        limit_reached;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      pending_lead:   LEAD_NONE,
      skip_left:      3'd0,
      skip_high_run:  1'b0,
      legal_flag:     1'b1,
      produced_count: 11'd0,
      limit_reached:  1'b0
   };

   // Input word
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic [7:0]  out_char;
      logic        char_valid;
      logic        end_of_string;
      logic        all_legal;
      logic [10:0] char_count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/utf8_to_latin1_decoder.sv -----
// Pipeline: a byte accepted into the input register is decoded into the result register
// once that register is free, and rsp_valid then rises if the byte gives a result word.
// Throughput: one byte per clock unless a held result is not taken (rsp_ready low), with
// the string state updated in the same cycle as the result register.
// Reset: synchronous, clears both word valid flags, the string state and sets
// out_limit to 1024; no clearing pass, bytes are accepted from the first cycle.
`default_nettype none

`include "utf8_to_latin1_decoder_macros.svh"

module utf8_to_latin1_decoder (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire u8l1dec_pkg::req_type  req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output u8l1dec_pkg::rsp_type       rsp_data,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire logic [10:0]           csr_data
);

   logic                   in_valid_ff, in_valid_in;
   u8l1dec_pkg::req_type   in_data_ff, in_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   u8l1dec_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   u8l1dec_pkg::state_type state_ff, state_in, state_next;
   logic [10:0]            out_limit_ff, out_limit_in;
   logic [10:0]            limit;
   logic                   advance;
   logic                   emit;
   u8l1dec_pkg::rsp_type   rsp_word;

   // Handshake: decode when a word is held and the result register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Limit in force
   assign limit = (out_limit_ff < u8l1dec_pkg::LIM_CAP) ? out_limit_ff : u8l1dec_pkg::LIM_CAP;

   u8l1dec_step u_step (
      .state_cur  (state_ff),
      .req_word   (in_data_ff),
      .limit      (limit),
      .state_next (state_next),
      .emit       (emit),
      .rsp_word   (rsp_word)
   );

   // Next values
   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      in_data_in   = (req_valid && req_ready) ? req_data : in_data_ff;
      state_in     = advance ? state_next : state_ff;
      rsp_valid_in = advance ? emit : (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = (advance && emit) ? rsp_word : rsp_data_ff;
      out_limit_in = csr_valid ? csr_data : out_limit_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= u8l1dec_pkg::STATE_CLEAR;
         out_limit_ff <= u8l1dec_pkg::LIM_CAP;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         out_limit_ff <= out_limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `U8L1_ASSERT_IMP(a_empty_only_at_end,
                    rsp_valid_ff && !rsp_data_ff.char_valid,
                    rsp_data_ff.end_of_string && (rsp_data_ff.out_char == 8'h00))
   `U8L1_ASSERT_IMP(a_count_nonzero,
                    rsp_valid_ff && rsp_data_ff.char_valid,
                    rsp_data_ff.char_count != 11'd0)
   `U8L1_ASSERT_IMP(a_count_capped, 1'b1, state_ff.produced_count <= u8l1dec_pkg::LIM_CAP)
   `U8L1_ASSERT_IMP(a_lead_alone,
                    state_ff.pending_lead != u8l1dec_pkg::LEAD_NONE,
                    !state_ff.limit_reached && (state_ff.skip_left == 3'd0))
   `U8L1_ASSERT_NXT(a_clear_after_end,
                    advance && in_data_ff.last_byte,
                    state_ff == u8l1dec_pkg::STATE_CLEAR)

endmodule

`default_nettype wire

// ----- design/u8l1dec_step.sv -----
`default_nettype none

// Decode one byte against the current string state
module u8l1dec_step (
   input  wire u8l1dec_pkg::state_type state_cur,
   input  wire u8l1dec_pkg::req_type   req_word,
   input  wire logic [10:0]            limit,
   output u8l1dec_pkg::state_type      state_next,
   output logic                        emit,
   output u8l1dec_pkg::rsp_type        rsp_word
);

   logic                   valid;
   logic [7:0]             ch;
   logic [7:0]             b;
   logic [10:0]            count_inc;
   u8l1dec_pkg::state_type upd;

   assign b         = req_word.in_byte;
   assign count_inc = state_cur.produced_count + 11'd1;

   // Main decode
   always_comb begin
      upd   = state_cur;
      valid = 1'b0;
      ch    = 8'h00;
      if (!state_cur.limit_reached) begin
         if (state_cur.pending_lead != u8l1dec_pkg::LEAD_NONE) begin
            // second byte of a two-byte sequence, taken whatever its value
            unique case (state_cur.pending_lead)
               u8l1dec_pkg::LEAD_C0: ch = b & u8l1dec_pkg::ASCII_MAX;
               u8l1dec_pkg::LEAD_C1: ch = (b | u8l1dec_pkg::BIT6_MASK) & u8l1dec_pkg::ASCII_MAX;
               u8l1dec_pkg::LEAD_C2: ch = b;
               default:              ch = b | u8l1dec_pkg::BIT6_MASK;
            endcase
            upd.pending_lead = u8l1dec_pkg::LEAD_NONE;
            valid            = 1'b1;
         end else if (state_cur.skip_left != 3'd0) begin
            upd.skip_left = state_cur.skip_left - 3'd1;
         end else if (state_cur.skip_high_run && (b >= u8l1dec_pkg::LEAD_LOW)) begin
            // still inside the run after FE or FF
         end else begin
            upd.skip_high_run = 1'b0;
            if (b <= u8l1dec_pkg::ASCII_MAX) begin
               ch    = b;
               valid = 1'b1;
            end else if ((b >= u8l1dec_pkg::LEAD_LOW) && (b <= u8l1dec_pkg::LEAD_HIGH)) begin
               // a lead on the final byte is dropped
               if (!req_word.last_byte) begin
                  upd.pending_lead = u8l1dec_pkg::lead_type'({1'b0, b[1:0]} + 3'd1);
               end
            end else begin
               upd.legal_flag = 1'b0;
               ch             = u8l1dec_pkg::SUBST_CHAR;
               valid          = 1'b1;
               if (b < u8l1dec_pkg::CLASS_3B) begin
                  upd.skip_left = 3'd1;
               end else if (b < u8l1dec_pkg::CLASS_4B) begin
                  upd.skip_left = 3'd2;
               end else if (b < u8l1dec_pkg::CLASS_5B) begin
                  upd.skip_left = 3'd3;
               end else if (b < u8l1dec_pkg::CLASS_6B) begin
                  upd.skip_left = 3'd4;
               end else if (b < u8l1dec_pkg::CLASS_RUN) begin
                  upd.skip_left = 3'd5;
               end else begin
                  upd.skip_high_run = 1'b1;
               end
            end
         end
         // character count and limit
         if (valid) begin
            upd.produced_count = count_inc;
            if (count_inc >= limit) begin
               upd.limit_reached = 1'b1;
            end
         end
      end
   end

   // Result word and end-of-string clear
   always_comb begin
      emit                   = valid || req_word.last_byte;
      rsp_word.out_char      = valid ? ch : 8'h00;
      rsp_word.char_valid    = valid;
      rsp_word.end_of_string = req_word.last_byte;
      rsp_word.all_legal     = upd.legal_flag;
      rsp_word.char_count    = upd.produced_count;
      state_next             = req_word.last_byte ? u8l1dec_pkg::STATE_CLEAR : upd;
   end

endmodule

`default_nettype wire
